[sv/prrs_pkg.sv]
// Shared types and constants for the priority round robin scheduler.
// No dependencies; imported by the scheduler core.
`default_nettype none

package prrs_pkg;

    // Field widths of the item and result channels
    localparam int ID_W     = 8;
    localparam int PRIO_W   = 4;
    localparam int BURST_W  = 12;
    localparam int STATUS_W = 2;
    localparam int QUANT_W  = 8;

    // APB configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // Register index (paddr[2]) of the quantum register
    localparam logic REG_QUANTUM = 1'b0;

    localparam logic [QUANT_W-1:0] QUANTUM_RESET = 8'd10;

    // Item operation codes
    localparam logic FUNC_ADD      = 1'b0;
    localparam logic FUNC_DISPATCH = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_ADDED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_SLICE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NONE  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd3;

    // One task entry: identifier and remaining run time
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [BURST_W-1:0] rem;
    } ent_word_t;

endpackage

`default_nettype wire

[sv/priority_round_robin_scheduler_core.sv]
// Priority scheduler core with round robin among tasks of equal priority.
// Depends on prrs_pkg (widths, status and operation codes, entry type).
// Flow: the level table is read at the input transfer; an add, full or no-ready result is
//   registered from it in S_LVL, while a dispatch first reads the head task's entry
//   and registers its result in S_ENT. Both wait while the result channel is full.
//   One item is worked on at a time: s_ready is low until the sequencer is idle again.
// Reset: synchronous, active low; clears control, counters and level valid bits and
//   sets quantum to 10. Task memories are not cleared and need no clearing pass.
`default_nettype none

module priority_round_robin_scheduler_core
    import prrs_pkg::*;
#(
    parameter int MAX_TASKS  = 64,
    parameter int NUM_LEVELS = 10
) (
    input  wire                   aclk,
    input  wire                   aresetn,

    // Item channel
    input  wire                   s_valid,
    output logic                  s_ready,
    input  wire                   s_func,
    input  wire  [ID_W-1:0]       s_task_id,
    input  wire  [PRIO_W-1:0]     s_priority_req,
    input  wire  [BURST_W-1:0]    s_burst,

    // Result channel
    output logic                  m_valid,
    input  wire                   m_ready,
    output logic [STATUS_W-1:0]   m_status,
    output logic [ID_W-1:0]       m_run_id,
    output logic [BURST_W-1:0]    m_slice,
    output logic                  m_finished,

    // APB configuration port
    input  wire                   psel,
    input  wire                   penable,
    input  wire                   pwrite,
    input  wire  [APB_ADDR_W-1:0] paddr,
    input  wire  [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;  // slot index
    localparam int CW = $clog2(MAX_TASKS + 1);                    // task count
    localparam int LW = $clog2(NUM_LEVELS);                       // level index

    localparam logic [CW-1:0] MAX_CNT     = CW'(MAX_TASKS);
    localparam logic [7:0]    NUM_LEVELS8 = 8'(NUM_LEVELS);

    // Sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;  // wait for an item transfer
    localparam logic [1:0] S_LVL  = 2'd1;  // level word is back; finish add or empty dispatch, or read entry
    localparam logic [1:0] S_ENT  = 2'd2;  // entry is back; finish dispatch

    // Per-level list descriptor
    typedef struct packed {
        logic [SW-1:0] head;
        logic [SW-1:0] tail;
        logic [CW-1:0] count;
    } lvl_word_t;

    // ------------------------------------------------------------------
    // Storage
    // ------------------------------------------------------------------
    // Task payload (id, remaining), list links, and the level table. Links of
    // freed slots double as the free list, so no separate free stack exists.
    ent_word_t     ent_mem [MAX_TASKS];
    logic [SW-1:0] nxt_mem [MAX_TASKS];
    lvl_word_t     lvl_mem [NUM_LEVELS];

    ent_word_t     ent_rdata_reg;
    logic [SW-1:0] nxt_rdata_reg;
    lvl_word_t     lvl_rdata_reg;

    // Control and bookkeeping registers
    logic [1:0]            state_reg,     state_next;
    logic                  func_reg,      func_next;
    logic [ID_W-1:0]       id_reg,        id_next;
    logic [BURST_W-1:0]    burst_reg,     burst_next;
    logic [LW-1:0]         lvl_reg,       lvl_next;
    logic                  lvl_vld_reg,   lvl_vld_next;
    logic                  none_reg,      none_next;
    logic                  full_reg,      full_next;
    logic [NUM_LEVELS-1:0] nonempty_reg,  nonempty_next;
    logic [SW-1:0]         free_head_reg, free_head_next;
    logic [CW-1:0]         rel_cnt_reg,   rel_cnt_next;   // slots on the free list
    logic [CW-1:0]         new_cnt_reg,   new_cnt_next;   // slots handed out fresh
    logic [QUANT_W-1:0]    quantum_reg,   quantum_next;

    logic                  m_valid_reg,    m_valid_next;
    logic [STATUS_W-1:0]   m_status_reg,   m_status_next;
    logic [ID_W-1:0]       m_run_id_reg,   m_run_id_next;
    logic [BURST_W-1:0]    m_slice_reg,    m_slice_next;
    logic                  m_finished_reg, m_finished_next;

    // Memory port controls
    logic                  accept;
    logic                  out_free;
    logic [LW-1:0]         in_lvl;
    logic [LW-1:0]         top_lvl;
    logic [7:0]            prio8;
    logic [7:0]            clamp8;

    logic                  ent_we,   ent_re;
    logic [SW-1:0]         ent_waddr;
    ent_word_t             ent_wdata;
    logic                  nxt_we,   nxt_re;
    logic [SW-1:0]         nxt_waddr, nxt_raddr, nxt_wdata;
    logic                  lvl_we;
    lvl_word_t             lvl_wdata;

    // Working values
    lvl_word_t             lvl_word;
    logic [SW-1:0]         alloc_slot;
    logic [QUANT_W-1:0]    q_eff;
    logic [BURST_W-1:0]    q_ext;
    logic                  rotate;
    logic                  cfg_wr;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_QUANTUM);

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_QUANTUM) begin
            prdata[QUANT_W-1:0] = quantum_reg;
        end
    end

    // ------------------------------------------------------------------
    // Handshakes and level selection
    // ------------------------------------------------------------------
    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign m_valid    = m_valid_reg;
    assign m_status   = m_status_reg;
    assign m_run_id   = m_run_id_reg;
    assign m_slice    = m_slice_reg;
    assign m_finished = m_finished_reg;

    // Highest non-empty level wins
    always_comb begin
        top_lvl = '0;
        for (int i = 0; i < NUM_LEVELS; i++) begin
            if (nonempty_reg[i]) begin
                top_lvl = LW'(i);
            end
        end
    end

    // Clamp requested priority into 1..NUM_LEVELS, then map to a level index
    always_comb begin
        prio8 = {{(8 - PRIO_W){1'b0}}, s_priority_req};
        if (prio8 == 8'd0) begin
            clamp8 = 8'd0;
        end else if (prio8 > NUM_LEVELS8) begin
            clamp8 = NUM_LEVELS8 - 8'd1;
        end else begin
            clamp8 = prio8 - 8'd1;
        end
    end

    assign in_lvl = (s_func == FUNC_DISPATCH) ? top_lvl : clamp8[LW-1:0];

    // A level without its valid bit reads as an empty descriptor
    assign lvl_word   = lvl_vld_reg ? lvl_rdata_reg : '0;
    // Reuse a released slot first, else hand out the next untouched one
    assign alloc_slot = (rel_cnt_reg != '0) ? free_head_reg : new_cnt_reg[SW-1:0];
    assign q_eff      = (quantum_reg == '0) ? QUANT_W'(1) : quantum_reg;
    assign q_ext      = {{(BURST_W - QUANT_W){1'b0}}, q_eff};
    assign rotate     = (lvl_word.count > CW'(1)) && (ent_rdata_reg.rem > q_ext);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next      = state_reg;
        func_next       = func_reg;
        id_next         = id_reg;
        burst_next      = burst_reg;
        lvl_next        = lvl_reg;
        lvl_vld_next    = lvl_vld_reg;
        none_next       = none_reg;
        full_next       = full_reg;
        nonempty_next   = nonempty_reg;
        free_head_next  = free_head_reg;
        rel_cnt_next    = rel_cnt_reg;
        new_cnt_next    = new_cnt_reg;
        quantum_next    = cfg_wr ? pwdata[QUANT_W-1:0] : quantum_reg;

        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_run_id_next   = m_run_id_reg;
        m_slice_next    = m_slice_reg;
        m_finished_next = m_finished_reg;

        ent_we    = 1'b0;
        ent_re    = 1'b0;
        ent_waddr = lvl_word.head;
        ent_wdata = '0;
        nxt_we    = 1'b0;
        nxt_re    = 1'b0;
        nxt_raddr = free_head_reg;
        nxt_waddr = lvl_word.tail;
        nxt_wdata = alloc_slot;
        lvl_we    = 1'b0;
        lvl_wdata = lvl_word;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    // Capture the item and launch the level read and, for an add, the free-link read
                    func_next    = s_func;
                    id_next      = s_task_id;
                    burst_next   = s_burst;
                    lvl_next     = in_lvl;
                    lvl_vld_next = nonempty_reg[in_lvl];
                    none_next    = (nonempty_reg == '0);
                    full_next    = (rel_cnt_reg == '0) && (new_cnt_reg == MAX_CNT);
                    nxt_re       = (s_func == FUNC_ADD);
                    nxt_raddr    = free_head_reg;
                    state_next   = S_LVL;
                end
            end

            S_LVL: begin
                if (func_reg == FUNC_DISPATCH && !none_reg) begin
                    // Fetch the head task and its link
                    ent_re     = 1'b1;
                    nxt_re     = 1'b1;
                    nxt_raddr  = lvl_word.head;
                    state_next = S_ENT;
                end else if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_run_id_next   = '0;
                    m_slice_next    = '0;
                    m_finished_next = 1'b0;
                    state_next      = S_IDLE;
                    if (func_reg == FUNC_DISPATCH) begin
                        m_status_next = STATUS_NONE;
                    end else if (full_reg) begin
                        m_status_next = STATUS_FULL;
                    end else begin
                        // Append the new task at the level tail
                        m_status_next = STATUS_ADDED;
                        ent_we        = 1'b1;
                        ent_waddr     = alloc_slot;
                        ent_wdata     = '{id: id_reg, rem: burst_reg};
                        nxt_we        = (lvl_word.count != '0);
                        nxt_waddr     = lvl_word.tail;
                        nxt_wdata     = alloc_slot;
                        lvl_we        = 1'b1;
                        lvl_wdata.head  = (lvl_word.count == '0) ? alloc_slot
                                                                  : lvl_word.head;
                        lvl_wdata.tail  = alloc_slot;
                        lvl_wdata.count = lvl_word.count + CW'(1);
                        nonempty_next[lvl_reg] = 1'b1;
                        if (rel_cnt_reg != '0) begin
                            // Pop the free list; its link was read at the transfer
                            rel_cnt_next   = rel_cnt_reg - CW'(1);
                            free_head_next = nxt_rdata_reg;
                        end else begin
                            new_cnt_next   = new_cnt_reg + CW'(1);
                        end
                    end
                end
            end

            S_ENT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = STATUS_SLICE;
                    m_run_id_next = ent_rdata_reg.id;
                    state_next    = S_IDLE;
                    lvl_we        = 1'b1;
                    lvl_wdata.head = nxt_rdata_reg;
                    if (rotate) begin
                        // Run one quantum, move the task to the level tail
                        m_slice_next    = q_ext;
                        m_finished_next = 1'b0;
                        ent_we          = 1'b1;
                        ent_waddr       = lvl_word.head;
                        ent_wdata       = '{id: ent_rdata_reg.id,
                                            rem: ent_rdata_reg.rem - q_ext};
                        nxt_we          = 1'b1;
                        nxt_waddr       = lvl_word.tail;
                        nxt_wdata       = lvl_word.head;
                        lvl_wdata.tail  = lvl_word.head;
                    end else begin
                        // Run to completion, drop from the level, release the slot
                        m_slice_next    = ent_rdata_reg.rem;
                        m_finished_next = 1'b1;
                        lvl_wdata.count = lvl_word.count - CW'(1);
                        if (lvl_word.count == CW'(1)) begin
                            nonempty_next[lvl_reg] = 1'b0;
                        end
                        nxt_we          = 1'b1;
                        nxt_waddr       = lvl_word.head;
                        nxt_wdata       = free_head_reg;
                        free_head_next  = lvl_word.head;
                        rel_cnt_next    = rel_cnt_reg + CW'(1);
                    end
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Memories: registered read, write at the clock edge
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (ent_we) begin
            ent_mem[ent_waddr] <= ent_wdata;
        end
        if (ent_re) begin
            ent_rdata_reg <= ent_mem[lvl_word.head];
        end
    end

    always_ff @(posedge aclk) begin
        if (nxt_we) begin
            nxt_mem[nxt_waddr] <= nxt_wdata;
        end
        if (nxt_re) begin
            nxt_rdata_reg <= nxt_mem[nxt_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (lvl_we) begin
            lvl_mem[lvl_reg] <= lvl_wdata;
        end
        if (accept) begin
            lvl_rdata_reg <= lvl_mem[in_lvl];
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            nonempty_reg  <= '0;
            rel_cnt_reg   <= '0;
            new_cnt_reg   <= '0;
            quantum_reg   <= QUANTUM_RESET;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            nonempty_reg  <= nonempty_next;
            rel_cnt_reg   <= rel_cnt_next;
            new_cnt_reg   <= new_cnt_next;
            quantum_reg   <= quantum_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg       <= func_next;
        id_reg         <= id_next;
        burst_reg      <= burst_next;
        lvl_reg        <= lvl_next;
        lvl_vld_reg    <= lvl_vld_next;
        none_reg       <= none_next;
        full_reg       <= full_next;
        free_head_reg  <= free_head_next;
        m_status_reg   <= m_status_next;
        m_run_id_reg   <= m_run_id_next;
        m_slice_reg    <= m_slice_next;
        m_finished_reg <= m_finished_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Released slots can never outnumber slots ever handed out
    a_free_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rel_cnt_reg <= new_cnt_reg)
        else $error("free list longer than allocated slots");

    // Every transfer leaves idle, so it is worked on before the next one
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == S_LVL))
        else $error("accepted item not started");

    // A dispatched level must hold at least one task
    a_level_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ENT) |-> (lvl_vld_reg && (lvl_word.count != '0)))
        else $error("dispatch from an empty level");

    // A rotating slice is reported valid, not finished and never empty
    a_rotate_slice: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ENT && out_free && rotate) |=>
            (m_valid_reg && !m_finished_reg && m_slice_reg != '0))
        else $error("rotating slice reported as finished or empty");

    // Nothing ready is only reported when every level was empty at transfer
    a_none_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_func == FUNC_DISPATCH && nonempty_reg != '0) |=> !none_reg)
        else $error("idle status with a ready level");

endmodule

`default_nettype wire
